/* rtl/stc_pkg.sv */
// Shared types, character codes and sizes for the shell token classifier.
package stc_pkg;

  localparam int unsigned LINE_BYTES = 1024;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned END_W  = 11;

  // Request kinds carried in s_axis_tuser
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef enum logic [2:0] {
    TT_END     = 3'd0,
    TT_WORD    = 3'd1,
    TT_INTERP  = 3'd2,
    TT_PIPE    = 3'd3,
    TT_IN      = 3'd4,
    TT_HEREDOC = 3'd5,
    TT_OUT     = 3'd6,
    TT_APPEND  = 3'd7
  } tok_type_e;

  typedef struct packed {
    tok_type_e        token_type;
    logic [END_W-1:0] token_end;
  } stc_result_t;

endpackage

/* rtl/stc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module stc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/stc_scan.sv */
// Token scan sequencer: walks the line store one byte per cycle.
module stc_scan #(
  parameter int unsigned LINE_BYTES = stc_pkg::LINE_BYTES,
  localparam int unsigned AW = $clog2(LINE_BYTES),
  localparam int unsigned IW = ($clog2(LINE_BYTES + 2) > stc_pkg::END_W) ?
                               $clog2(LINE_BYTES + 2) : stc_pkg::END_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [stc_pkg::POS_W-1:0]    pos_i,
  output logic                         ready_o,
  output logic [AW-1:0]                rd_addr_o,
  input  logic [stc_pkg::BYTE_W-1:0]   rd_data_i,
  output logic                         res_valid_o,
  output stc_pkg::stc_result_t         res_o,
  input  logic                         res_take_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIRST  = 6'b000010,
    S_SECOND = 6'b000100,
    S_WORD   = 6'b001000,
    S_QUOTE  = 6'b010000,
    S_DONE   = 6'b100000
  } scan_state_e;

  scan_state_e state_q, state_d;
  logic [IW-1:0] start_q, start_d;
  logic [IW-1:0] e_q, e_d;
  logic [IW-1:0] k_q, k_d;
  logic [7:0]    quote_q, quote_d;
  logic [7:0]    redir_q, redir_d;
  stc_pkg::tok_type_e type_q, type_d;
  stc_pkg::stc_result_t res_q, res_d;
  logic          oob_q;
  logic [IW-1:0] rd_idx;
  logic [7:0]    c;
  logic          do_word;
  logic          brk;

  // Reads past the store act as the end of the line
  assign c = oob_q ? stc_pkg::CH_NUL : rd_data_i;
  assign brk = (c == stc_pkg::CH_SPACE) || (c == stc_pkg::CH_LT) ||
               (c == stc_pkg::CH_GT) || (c == stc_pkg::CH_PIPE);

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    e_d     = e_q;
    k_d     = k_q;
    quote_d = quote_q;
    redir_d = redir_q;
    type_d  = type_q;
    res_d   = res_q;
    rd_idx  = e_q;
    do_word = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_idx = IW'(pos_i);
        if (start_i) begin
          start_d = IW'(pos_i);
          e_d     = IW'(pos_i);
          type_d  = stc_pkg::TT_WORD;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (c == stc_pkg::CH_PIPE) begin
          res_d   = '{token_type: stc_pkg::TT_PIPE,
                      token_end: stc_pkg::END_W'(start_q + IW'(1))};
          state_d = S_DONE;
        end else if ((c == stc_pkg::CH_LT) || (c == stc_pkg::CH_GT)) begin
          redir_d = c;
          rd_idx  = start_q + IW'(1);
          state_d = S_SECOND;
        end else if (c == stc_pkg::CH_NUL) begin
          res_d   = '{token_type: stc_pkg::TT_END,
                      token_end: stc_pkg::END_W'(start_q)};
          state_d = S_DONE;
        end else begin
          do_word = 1'b1;
        end
      end
      S_SECOND: begin
        if (c == redir_q) begin
          res_d.token_type = (redir_q == stc_pkg::CH_LT) ? stc_pkg::TT_HEREDOC :
                                                           stc_pkg::TT_APPEND;
          res_d.token_end  = stc_pkg::END_W'(start_q + IW'(2));
        end else begin
          res_d.token_type = (redir_q == stc_pkg::CH_LT) ? stc_pkg::TT_IN :
                                                           stc_pkg::TT_OUT;
          res_d.token_end  = stc_pkg::END_W'(start_q + IW'(1));
        end
        state_d = S_DONE;
      end
      S_WORD: begin
        do_word = 1'b1;
      end
      S_QUOTE: begin
        if (c == stc_pkg::CH_NUL) begin
          // no partner: the quote is an ordinary character
          e_d     = e_q + IW'(1);
          rd_idx  = e_q + IW'(1);
          state_d = S_WORD;
        end else if (c == quote_q) begin
          type_d  = stc_pkg::TT_INTERP;
          e_d     = k_q + IW'(1);
          rd_idx  = k_q + IW'(1);
          state_d = S_WORD;
        end else begin
          k_d    = k_q + IW'(1);
          rd_idx = k_q + IW'(1);
        end
      end
      S_DONE: begin
        rd_idx = IW'(pos_i);
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_word) begin
      if ((c == stc_pkg::CH_NUL) || brk) begin
        res_d   = '{token_type: type_q, token_end: stc_pkg::END_W'(e_q)};
        state_d = S_DONE;
      end else if ((c == stc_pkg::CH_SQUOTE) || (c == stc_pkg::CH_DQUOTE)) begin
        quote_d = c;
        k_d     = e_q + IW'(1);
        rd_idx  = e_q + IW'(1);
        state_d = S_QUOTE;
      end else begin
        if (c == stc_pkg::CH_DOLLAR) begin
          type_d = stc_pkg::TT_INTERP;
        end
        e_d     = e_q + IW'(1);
        rd_idx  = e_q + IW'(1);
        state_d = S_WORD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    e_q     <= e_d;
    k_q     <= k_d;
    quote_q <= quote_d;
    redir_q <= redir_d;
    type_q  <= type_d;
    res_q   <= res_d;
    oob_q   <= (rd_idx >= IW'(LINE_BYTES));
  end

  assign rd_addr_o   = rd_idx[AW-1:0];
  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

/* rtl/shell_token_classifier_core.sv */
// Shell token classifier top level: line store, scan sequencer, output register.
// Write request: gives no result; writes can follow every cycle while no classify is in progress.
// Classify request: the scan reads at least one byte from the line store, including each
//   byte read while searching for a closing quote, then hands the result to the output
//   register; no new request is taken until the result has gone to the output register.
// A full output register that the receiver does not take holds the scanner and blocks further requests.
// Reset clears control state; line store contents are undefined until written.
module shell_token_classifier_core #(
  parameter int unsigned LINE_BYTES = stc_pkg::LINE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // position[9:0], byte_value[17:10], zero pad
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // token_end[10:0], zero pad
  output logic [2:0]  m_axis_tuser   // token_type[2:0]
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam int unsigned CW = ($clog2(LINE_BYTES + 1) > stc_pkg::POS_W) ?
                               $clog2(LINE_BYTES + 1) : stc_pkg::POS_W + 1;

  logic [stc_pkg::POS_W-1:0]  pos;
  logic [stc_pkg::BYTE_W-1:0] wbyte;
  logic                       accept;
  logic                       wr_en;
  logic                       cls_start;
  logic                       scan_ready;
  logic [AW-1:0]              rd_addr;
  logic [stc_pkg::BYTE_W-1:0] rd_data;
  logic                       res_valid;
  logic                       res_take;
  stc_pkg::stc_result_t       res;
  logic                       out_valid_q;
  stc_pkg::stc_result_t       out_q;

  assign pos       = s_axis_tdata[stc_pkg::POS_W-1:0];
  assign wbyte     = s_axis_tdata[stc_pkg::POS_W +: stc_pkg::BYTE_W];
  assign accept    = s_axis_tvalid && s_axis_tready;
  // writes past the store are dropped
  assign wr_en     = accept && (s_axis_tuser[0] == stc_pkg::OP_WRITE) &&
                     (CW'(pos) < CW'(LINE_BYTES));
  assign cls_start = accept && (s_axis_tuser[0] == stc_pkg::OP_CLASSIFY);
  assign s_axis_tready = scan_ready;

  stc_ram #(
    .WIDTH (stc_pkg::BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(pos)),
    .wdata_i (wbyte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  stc_scan #(
    .LINE_BYTES (LINE_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cls_start),
    .pos_i       (pos),
    .ready_o     (scan_ready),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign res_take = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.token_end};
  assign m_axis_tuser  = out_q.token_type;

  // a classify request occupies the scanner, so the next cycle takes nothing
  a_classify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser[0] == stc_pkg::OP_CLASSIFY)) |=> !s_axis_tready)
    else $error("input taken right after a classify request");

  // a write request never creates a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser[0] == stc_pkg::OP_WRITE) && !m_axis_tvalid)
    |=> !m_axis_tvalid)
    else $error("result appeared after a write request");

  // single-byte operator tokens end past their start, so their end index is never zero
  a_op_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == stc_pkg::TT_PIPE) ||
                       (m_axis_tuser == stc_pkg::TT_IN) ||
                       (m_axis_tuser == stc_pkg::TT_OUT)))
    |-> (m_axis_tdata[stc_pkg::END_W-1:0] != '0))
    else $error("operator token with zero end index");

  // the scanner only presents a result it can hand off or hold
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_take) |=> res_valid)
    else $error("scan result dropped while output register full");

endmodule

/* dv/tb_shell_token_classifier_core.sv */
// Testbench for shell_token_classifier_core: scoreboarded line writes and token classifies.
module tb_shell_token_classifier_core;

  localparam int unsigned LINE_BYTES   = stc_pkg::LINE_BYTES;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_PAD    = 64;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // position[9:0], byte_value[17:10], zero pad
  logic [0:0]  s_axis_tuser  = '0;  // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // token_end[10:0], zero pad
  logic [2:0]  m_axis_tuser;        // token_type[2:0]

  shell_token_classifier_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Shadow of the line store; only written entries may be read by a classify.
  logic [7:0]  line_mem     [LINE_BYTES];
  bit          line_written [LINE_BYTES];
  bit          scan_ok;

  stc_pkg::stc_result_t tok_q[$];
  stc_pkg::stc_result_t last_tok;
  bit                   last_sent;
  stc_pkg::stc_result_t chk_tok;

  int unsigned fail_cnt   = 0;
  int unsigned n_writes   = 0;
  int unsigned n_classify = 0;
  int unsigned n_checked  = 0;
  int unsigned type_hits [8];
  int unsigned cyc_cnt    = 0;
  int unsigned burst_left = 0;
  bit          bursty     = 1'b1;

  // receiver stall control
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned rcv_mode   = 0;
  int unsigned rcv_cyc    = 0;
  int unsigned rcv_phase  = 0;

  initial begin
    for (int i = 0; i < LINE_BYTES; i++) begin
      line_mem[i]     = 8'h00;
      line_written[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) type_hits[i] = 0;
  end

  function automatic logic [7:0] peek(input int idx);
    if (idx >= LINE_BYTES) return stc_pkg::CH_NUL;   // past the store reads as end of line
    if (!line_written[idx]) scan_ok = 1'b0;
    return line_mem[idx];
  endfunction

  function automatic bit is_brk(input logic [7:0] c);
    return (c == stc_pkg::CH_SPACE) || (c == stc_pkg::CH_LT) ||
           (c == stc_pkg::CH_GT) || (c == stc_pkg::CH_PIPE);
  endfunction

  // Token lexer: type and end index of the token at start; scan_ok drops on unwritten reads.
  function automatic stc_pkg::stc_result_t lex_token(input logic [stc_pkg::POS_W-1:0] start);
    logic [7:0]           c;
    logic [7:0]           q;
    int                   s;
    int                   e;
    int                   k;
    bit                   closed;
    stc_pkg::tok_type_e   typ;
    stc_pkg::stc_result_t r;
    scan_ok = 1'b1;
    s   = int'(start);
    e   = s;
    typ = stc_pkg::TT_WORD;
    c   = peek(s);
    if (c == stc_pkg::CH_PIPE) begin
      typ = stc_pkg::TT_PIPE;
      e   = s + 1;
    end else if (c == stc_pkg::CH_LT) begin
      if (peek(s + 1) == stc_pkg::CH_LT) begin
        typ = stc_pkg::TT_HEREDOC;
        e   = s + 2;
      end else begin
        typ = stc_pkg::TT_IN;
        e   = s + 1;
      end
    end else if (c == stc_pkg::CH_GT) begin
      if (peek(s + 1) == stc_pkg::CH_GT) begin
        typ = stc_pkg::TT_APPEND;
        e   = s + 2;
      end else begin
        typ = stc_pkg::TT_OUT;
        e   = s + 1;
      end
    end else if (c == stc_pkg::CH_NUL) begin
      typ = stc_pkg::TT_END;
    end else begin
      while (c != stc_pkg::CH_NUL && !is_brk(c)) begin
        if (c == stc_pkg::CH_SQUOTE || c == stc_pkg::CH_DQUOTE) begin
          // a quote only counts if its partner shows up before end of line
          k      = e + 1;
          closed = 1'b0;
          q      = peek(k);
          while (q != stc_pkg::CH_NUL && !closed) begin
            if (q == c) closed = 1'b1;
            else begin
              k++;
              q = peek(k);
            end
          end
          if (closed) begin
            typ = stc_pkg::TT_INTERP;
            e   = k;
          end
        end else if (c == stc_pkg::CH_DOLLAR) begin
          typ = stc_pkg::TT_INTERP;
        end
        e++;
        c = peek(e);
      end
    end
    r.token_type = typ;
    r.token_end  = e[stc_pkg::END_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return 8'(8'h61 + $urandom_range(0, 25));
      6:       return stc_pkg::CH_SPACE;
      7:       return stc_pkg::CH_LT;
      8:       return stc_pkg::CH_GT;
      9:       return stc_pkg::CH_PIPE;
      10:      return stc_pkg::CH_SQUOTE;
      11:      return stc_pkg::CH_DQUOTE;
      12:      return stc_pkg::CH_DOLLAR;
      13:      return 8'(8'h30 + $urandom_range(0, 9));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Offers one request starting at a falling edge; returns at the falling edge after it is taken.
  // A classify that would read an unwritten entry is dropped and last_sent stays low.
  task automatic send_req(input logic op, input logic [stc_pkg::POS_W-1:0] pos,
                          input logic [stc_pkg::BYTE_W-1:0] val);
    int unsigned gap;
    last_sent = 1'b0;
    if (op == stc_pkg::OP_CLASSIFY) begin
      last_tok = lex_token(pos);
      if (!scan_ok) return;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (bursty && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tdata  = {6'b0, val, pos};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == stc_pkg::OP_WRITE) begin
      line_mem[pos]     = val;
      line_written[pos] = 1'b1;
      n_writes++;
    end else begin
      tok_q.push_back(last_tok);
      n_classify++;
    end
    last_sent = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic write_text(input int base, input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_req(stc_pkg::OP_WRITE, stc_pkg::POS_W'(base + i), text[i]);
    end
    send_req(stc_pkg::OP_WRITE, stc_pkg::POS_W'(base + text.len()), stc_pkg::CH_NUL);
  endtask

  // Idle the sender until every expected result is back, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (tok_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed_tokens();
    // pipe, heredoc, input, append, output, space start, quoted word, lone quote, end
    write_text(0, "|<<<>>> a'bc'\"d\"$ \"x");
    send_req(stc_pkg::OP_WRITE, 10, 8'hFF);
    send_req(stc_pkg::OP_CLASSIFY, 0, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 1, 8'hFF);
    send_req(stc_pkg::OP_CLASSIFY, 3, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 4, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 6, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 7, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 8, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 18, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 20, 8'h00);
    wait_drained();
  endtask

  task automatic test_store_end();
    // redirects and words that run into the end of the store
    send_req(stc_pkg::OP_WRITE, 1021, "z");
    send_req(stc_pkg::OP_WRITE, 1022, stc_pkg::CH_GT);
    send_req(stc_pkg::OP_WRITE, 1023, stc_pkg::CH_GT);
    send_req(stc_pkg::OP_CLASSIFY, 1023, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 1022, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 1021, 8'h00);
    send_req(stc_pkg::OP_WRITE, 1023, stc_pkg::CH_LT);
    send_req(stc_pkg::OP_CLASSIFY, 1023, 8'h00);
    send_req(stc_pkg::OP_CLASSIFY, 1022, 8'h00);
    send_req(stc_pkg::OP_WRITE, 1022, stc_pkg::CH_LT);
    send_req(stc_pkg::OP_CLASSIFY, 1022, 8'h00);
    send_req(stc_pkg::OP_WRITE, 1022, "a");
    send_req(stc_pkg::OP_WRITE, 1023, "b");
    send_req(stc_pkg::OP_CLASSIFY, 1021, 8'h00);
    wait_drained();
  endtask

  task automatic test_output_stall();
    // receiver blocks for a long stretch while classifies keep coming
    bursty = 1'b0;
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 24; i++) begin
      send_req(stc_pkg::OP_CLASSIFY, stc_pkg::POS_W'($urandom_range(0, 21)), 8'($urandom));
    end
    bursty = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_lines(input int unsigned n_items);
    int unsigned target;
    int unsigned next_drain;
    int          base;
    int          len;
    int          p;
    int          steps;
    target     = n_writes + n_classify + n_items;
    next_drain = n_writes + n_classify + 200;
    while (n_writes + n_classify < target) begin
      if (n_writes + n_classify >= next_drain) begin
        wait_drained();
        next_drain += 200;
      end
      case ($urandom_range(0, 9))
        8: send_req(stc_pkg::OP_WRITE, stc_pkg::POS_W'($urandom_range(0, LINE_BYTES - 1)),
                    8'($urandom));
        9: send_req(stc_pkg::OP_CLASSIFY, stc_pkg::POS_W'($urandom_range(0, LINE_BYTES - 1)),
                    8'($urandom));
        default: begin
          base = ($urandom_range(0, 9) == 0) ?
                 $urandom_range(LINE_BYTES - 24, LINE_BYTES - 1) :
                 $urandom_range(0, LINE_BYTES - 1);
          len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
          if (base + len > LINE_BYTES) len = LINE_BYTES - base;
          for (int i = 0; i < len; i++) begin
            send_req(stc_pkg::OP_WRITE, stc_pkg::POS_W'(base + i), rand_char());
          end
          if (base + len < LINE_BYTES) begin
            send_req(stc_pkg::OP_WRITE, stc_pkg::POS_W'(base + len), stc_pkg::CH_NUL);
          end
          if ($urandom_range(0, 1) == 0) begin
            // lex the line token by token
            p     = base;
            steps = 0;
            while (steps < 16 && p < LINE_BYTES) begin
              send_req(stc_pkg::OP_CLASSIFY, stc_pkg::POS_W'(p), 8'($urandom));
              if (!last_sent || last_tok.token_type == stc_pkg::TT_END) break;
              p = (int'(last_tok.token_end) == p) ? p + 1 : int'(last_tok.token_end);
              steps++;
            end
          end else begin
            repeat ($urandom_range(2, 6)) begin
              p = $urandom_range(base, base + len);
              if (p >= LINE_BYTES) p = LINE_BYTES - 1;
              send_req(stc_pkg::OP_CLASSIFY, stc_pkg::POS_W'(p), 8'($urandom));
            end
          end
        end
      endcase
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rcv_cyc == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_cyc  = $urandom_range(20, 120);
    end else begin
      rcv_cyc--;
    end
    rcv_phase++;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      case (rcv_mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = 1'($urandom_range(0, 1));
        2:       m_axis_tready = (rcv_phase % 4 == 0);
        default: m_axis_tready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tok_q.size() == 0) begin
        $error("result with nothing expected: token_type %0d token_end %0d",
               m_axis_tuser, m_axis_tdata[stc_pkg::END_W-1:0]);
        fail_cnt++;
      end else begin
        chk_tok = tok_q.pop_front();
        if (m_axis_tuser !== chk_tok.token_type) begin
          $error("token_type mismatch: expected %0d, actual %0d",
                 chk_tok.token_type, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[stc_pkg::END_W-1:0] !== chk_tok.token_end) begin
          $error("token_end mismatch: expected %0d, actual %0d",
                 chk_tok.token_end, m_axis_tdata[stc_pkg::END_W-1:0]);
          fail_cnt++;
        end
        type_hits[chk_tok.token_type]++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt, tok_q.size());
      $display("shell_token_classifier_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_tokens();
    test_store_end();
    test_output_stall();
    test_random_lines(1000);
    wait_drained();
    $display("Ran %0d line writes and %0d classifies; %0d results checked.",
             n_writes, n_classify, n_checked);
    $display("Tokens: end %0d word %0d interp %0d pipe %0d in %0d heredoc %0d out %0d",
             type_hits[stc_pkg::TT_END], type_hits[stc_pkg::TT_WORD],
             type_hits[stc_pkg::TT_INTERP], type_hits[stc_pkg::TT_PIPE],
             type_hits[stc_pkg::TT_IN], type_hits[stc_pkg::TT_HEREDOC],
             type_hits[stc_pkg::TT_OUT]);
    $display("        append %0d", type_hits[stc_pkg::TT_APPEND]);
    if (fail_cnt == 0 && tok_q.size() == 0) begin
      $display("shell_token_classifier_core test passed");
    end else begin
      $display("shell_token_classifier_core test failed");
    end
    $finish;
  end

endmodule
